FILE: src/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// shared constants and helpers for the rmc position parser
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam int unsigned ACC_W   = 31;
  localparam int unsigned POW_W   = 20;
  localparam int unsigned FRAC_W  = 3;
  localparam int unsigned HPOS_W  = 3;
  localparam int unsigned FIDX_W  = 3;

  localparam logic [HPOS_W-1:0] HDR_LAST = 3'd6;
  localparam logic [ACC_W-1:0]  SAT_MAX  = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;

  localparam logic [FIDX_W-1:0] FLD_STATUS = 3'd1;
  localparam logic [FIDX_W-1:0] FLD_LAT    = 3'd2;
  localparam logic [FIDX_W-1:0] FLD_NS     = 3'd3;
  localparam logic [FIDX_W-1:0] FLD_LON    = 3'd4;
  localparam logic [FIDX_W-1:0] FLD_EW     = 3'd5;
  localparam logic [FIDX_W-1:0] FLD_SPEED  = 3'd6;
  localparam logic [FIDX_W-1:0] FLD_MAX    = 3'd7;

  // "$GPRMC,"
  function automatic logic [7:0] hdr_char(input logic [HPOS_W-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      3'd6:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [POW_W-1:0] p;
    unique case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: src/nrmc_scale.sv
// ----------------------------------------------------------------------------
// nrmc_scale
// saturating multiply of a parsed number by a power of ten
// ----------------------------------------------------------------------------
module nrmc_scale
  import nrmc_pkg::*;
(
  input  logic [ACC_W-1:0]  value_i,
  input  logic [FRAC_W-1:0] shift_i,
  output logic [ACC_W-1:0]  result_o
);

  localparam int unsigned PROD_W = ACC_W + POW_W;

  logic [PROD_W-1:0] prod;

  assign prod     = PROD_W'(value_i) * PROD_W'(pow10(shift_i));
  assign result_o = (prod > PROD_W'(SAT_MAX)) ? SAT_MAX : prod[ACC_W-1:0];

endmodule

FILE: src/nmea_rmc_position_parser.sv
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser
// rmc sentence parser giving latitude, longitude and speed per accepted sentence
// ----------------------------------------------------------------------------
// result: written on the '*' byte into the output register, or the skid register when held
// throughput: one byte per cycle while the skid register is empty, set by the single-pass parse
// and field close; output register plus one skid register; input stalls only when both are full
// reset: asynchronous, clears the matcher, field state, held values and queue
// ----------------------------------------------------------------------------
module nmea_rmc_position_parser
  import nrmc_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 80,
  parameter int unsigned FRAC_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o    // latitude, longitude, speed, all_fields_seen
);

  localparam int unsigned BCNT_W = $clog2(MAX_LEN + 2);
  localparam logic [BCNT_W-1:0] MAX_LEN_C = BCNT_W'(MAX_LEN);
  localparam logic [FRAC_W-1:0] FRAC_C    = FRAC_W'(FRAC_DIGITS);

  logic [HPOS_W-1:0] hpos_q, hpos_d;
  logic              in_body_q, in_body_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;
  logic              rej_q, rej_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              after_q, after_d;
  logic [7:0]        ffc_q, ffc_d;
  logic [31:0]       lat_q, lat_d;
  logic [31:0]       lon_q, lon_d;
  logic [ACC_W-1:0]  spd_q, spd_d;

  logic [95:0] out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  logic              accept;
  logic              emit;
  logic              seen;
  logic [7:0]        ch;
  logic [BCNT_W-1:0] bcnt_inc;
  logic [34:0]       mac;
  logic [ACC_W-1:0]  mac_sat;
  logic [ACC_W-1:0]  scaled;
  logic              empty;
  logic [95:0]       result;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign ch     = s_axis_tdata_i;

  assign mac     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(ch - CH_ZERO);
  assign mac_sat = (mac > 35'(SAT_MAX)) ? SAT_MAX : mac[ACC_W-1:0];
  assign empty   = (ffc_q == 8'h00);
  assign bcnt_inc = bcnt_q + BCNT_W'(1);

  nrmc_scale u_scale (
    .value_i  (acc_q),
    .shift_i  (FRAC_C - frac_q),
    .result_o (scaled)
  );

  always_comb begin
    hpos_d    = hpos_q;
    in_body_d = in_body_q;
    fidx_d    = fidx_q;
    bcnt_d    = bcnt_q;
    rej_d     = rej_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    after_d   = after_q;
    ffc_d     = ffc_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    spd_d     = spd_q;
    emit      = 1'b0;
    seen      = (fidx_q >= FLD_SPEED);
    if (!in_body_q) begin
      if (ch == hdr_char(hpos_q)) begin
        if (hpos_q == HDR_LAST) begin
          hpos_d    = '0;
          in_body_d = 1'b1;
          fidx_d    = '0;
          bcnt_d    = '0;
          rej_d     = 1'b0;
          acc_d     = '0;
          frac_d    = '0;
          after_d   = 1'b0;
          ffc_d     = '0;
        end else begin
          hpos_d = hpos_q + HPOS_W'(1);
        end
      end else begin
        hpos_d = '0;
      end
    end else begin
      bcnt_d = bcnt_inc;
      if (bcnt_inc > MAX_LEN_C) begin
        in_body_d = 1'b0;
        hpos_d    = '0;
      end else if (ch == CH_STAR || ch == CH_COMMA) begin
        // close the current field
        if (!rej_q) begin
          case (fidx_q)
            FLD_STATUS: if (ffc_q != CH_A) rej_d = 1'b1;
            FLD_LAT:    if (!empty) lat_d = {1'b0, scaled};
            FLD_NS:     if (!empty && ffc_q != CH_N) lat_d = 32'd0 - lat_q;
            FLD_LON:    if (!empty) lon_d = {1'b0, scaled};
            FLD_EW:     if (!empty && ffc_q != CH_E) lon_d = 32'd0 - lon_q;
            FLD_SPEED:  if (!empty) spd_d = scaled;
            default:    ;
          endcase
        end
        if (fidx_q != FLD_MAX) fidx_d = fidx_q + FIDX_W'(1);
        acc_d   = '0;
        frac_d  = '0;
        after_d = 1'b0;
        ffc_d   = '0;
        if (ch == CH_STAR) begin
          in_body_d = 1'b0;
          hpos_d    = '0;
          emit      = !rej_d;
        end
      end else begin
        if (empty) ffc_d = ch;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          if (!after_q) begin
            acc_d = mac_sat;
          end else if (frac_q < FRAC_C) begin
            acc_d  = mac_sat;
            frac_d = frac_q + FRAC_W'(1);
          end
        end else if (ch == CH_POINT && !after_q) begin
          after_d = 1'b1;
        end
      end
    end
  end

  assign result = {seen, spd_d, lon_d, lat_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q    <= '0;
      in_body_q <= 1'b0;
      fidx_q    <= '0;
      bcnt_q    <= '0;
      rej_q     <= 1'b0;
      acc_q     <= '0;
      frac_q    <= '0;
      after_q   <= 1'b0;
      ffc_q     <= '0;
      lat_q     <= '0;
      lon_q     <= '0;
      spd_q     <= '0;
    end else if (accept) begin
      hpos_q    <= hpos_d;
      in_body_q <= in_body_d;
      fidx_q    <= fidx_d;
      bcnt_q    <= bcnt_d;
      rej_q     <= rej_d;
      acc_q     <= acc_d;
      frac_q    <= frac_d;
      after_q   <= after_d;
      ffc_q     <= ffc_d;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
      spd_q     <= spd_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || m_axis_tready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept && emit;
        end
      end else if (accept && emit) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : result;
    end
    if (out_valid_q && !m_axis_tready_i && accept && emit) begin
      skid_q <= result;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transaction while output register is empty");

  a_hdr_idle_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (hpos_q == '0))
    else $error("header matcher active inside a sentence body");

  a_emit_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit) |-> in_body_q)
    else $error("result produced outside a sentence body");

  a_bcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (bcnt_q <= MAX_LEN_C))
    else $error("body byte count exceeds the sentence length limit");

endmodule

FILE: tb/tb_nmea_rmc_position_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_rmc_position_parser
// byte-stream regression for the rmc position parser: directed sentences for
// header resync, empty and dropped fields, saturation, truncation and length
// limits, then random well-formed and broken sentences mixed with line noise;
// every accepted byte goes through a local sentence tracker whose fixes are
// compared field by field with the master-side transactions
// ----------------------------------------------------------------------------
module tb_nmea_rmc_position_parser
  import nrmc_pkg::*;
();

  localparam int unsigned SENTENCE_MAX = 80;
  localparam int unsigned SCALE_DIGITS = 5;
  localparam int          BYTE_TARGET  = 1300;
  localparam logic [31:0] SAT_LIMIT    = 32'h7FFF_FFFF;
  localparam logic [55:0] RMC_HEADER   = "$GPRMC,";

  typedef struct {
    logic [31:0] lat;
    logic [31:0] lon;
    logic [30:0] speed;
    logic        all_seen;
  } rmc_fix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;           // latitude, longitude, speed, all_fields_seen

  logic [7:0] nmea_bytes[$];
  rmc_fix_t   expected_fixes[$];
  int         total_bytes;
  int         sentences_built;
  int         bytes_sent;
  int         fixes_checked;
  int         mismatches;

  // sentence tracker state
  int          hunt_pos;
  bit          in_sentence;
  logic [2:0]  field_no;
  int          body_len;
  bit          dropped;
  logic [31:0] acc;
  int          frac_cnt;
  bit          seen_point;
  logic [7:0]  first_ch;
  logic [31:0] held_lat;
  logic [31:0] held_lon;
  logic [31:0] held_speed;

  nmea_rmc_position_parser #(
    .MAX_LEN    (SENTENCE_MAX),
    .FRAC_DIGITS(SCALE_DIGITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- tracker
  function automatic logic [31:0] sat_mul10_add(input logic [31:0] v, input logic [31:0] d);
    if (v > (SAT_LIMIT - d) / 32'd10) return SAT_LIMIT;
    return v * 32'd10 + d;
  endfunction

  function automatic logic [31:0] scaled_value();
    logic [31:0] v;
    v = acc;
    for (int k = frac_cnt; k < SCALE_DIGITS; k++) v = sat_mul10_add(v, 32'd0);
    return v;
  endfunction

  task automatic reset_field();
    acc        = '0;
    frac_cnt   = 0;
    seen_point = 1'b0;
    first_ch   = 8'h00;
  endtask

  task automatic close_field();
    bit empty;
    empty = (first_ch == 8'h00);
    if (!dropped) begin
      case (field_no)
        FLD_STATUS: if (first_ch != CH_A) dropped = 1'b1;
        FLD_LAT:    if (!empty) held_lat = scaled_value();
        FLD_NS:     if (!empty && first_ch != CH_N) held_lat = 32'd0 - held_lat;
        FLD_LON:    if (!empty) held_lon = scaled_value();
        FLD_EW:     if (!empty && first_ch != CH_E) held_lon = 32'd0 - held_lon;
        FLD_SPEED:  if (!empty) held_speed = scaled_value();
        default: ;
      endcase
    end
    if (field_no < FLD_MAX) field_no = field_no + 3'd1;
    reset_field();
  endtask

  task automatic take_field_char(input logic [7:0] ch);
    if (first_ch == 8'h00) first_ch = ch;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (!seen_point) begin
        acc = sat_mul10_add(acc, 32'(ch - CH_ZERO));
      end else if (frac_cnt < SCALE_DIGITS) begin
        acc = sat_mul10_add(acc, 32'(ch - CH_ZERO));
        frac_cnt++;
      end
    end else if (ch == CH_POINT && !seen_point) begin
      seen_point = 1'b1;
    end
  endtask

  task automatic track_rmc_byte(input logic [7:0] ch);
    rmc_fix_t fix;
    bit       reached_speed;
    if (!in_sentence) begin
      if (hunt_pos < 7 && ch == RMC_HEADER[8*(6-hunt_pos) +: 8]) begin
        hunt_pos++;
        if (hunt_pos >= 7) begin
          hunt_pos    = 0;
          in_sentence = 1'b1;
          field_no    = '0;
          body_len    = 0;
          dropped     = 1'b0;
          reset_field();
        end
      end else begin
        hunt_pos = 0;
      end
      return;
    end
    body_len++;
    if (body_len > SENTENCE_MAX) begin
      in_sentence = 1'b0;
      hunt_pos    = 0;
      return;
    end
    if (ch == CH_STAR) begin
      reached_speed = (field_no >= FLD_SPEED);
      close_field();
      in_sentence = 1'b0;
      hunt_pos    = 0;
      if (!dropped) begin
        fix.lat      = held_lat;
        fix.lon      = held_lon;
        fix.speed    = held_speed[30:0];
        fix.all_seen = reached_speed;
        expected_fixes.push_back(fix);
      end
      return;
    end
    if (ch == CH_COMMA) close_field();
    else take_field_char(ch);
  endtask

  // -------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b);
    nmea_bytes.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) nmea_bytes.push_back(s[i]);
  endtask

  task automatic push_digit();
    push_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // sentence whose body, '*' included, is exactly len bytes
  task automatic add_padded(input string body, input int len);
    push_text("$GPRMC,");
    push_text(body);
    repeat (len - body.len() - 1) push_byte(CH_ZERO + 8'd7);
    push_byte(CH_STAR);
    sentences_built++;
  endtask

  task automatic add_number();
    int int_digits;
    case ($urandom_range(19))
      0:       return;
      1:       int_digits = $urandom_range(6, 12);
      default: int_digits = $urandom_range(0, 4);
    endcase
    repeat (int_digits) push_digit();
    if ($urandom_range(3) != 0) begin
      push_byte(CH_POINT);
      repeat ($urandom_range(0, 7)) push_digit();
    end
    if ($urandom_range(11) == 0) begin
      case ($urandom_range(2))
        0:       push_byte(CH_POINT);
        1:       push_text("-");
        default: push_byte(8'($urandom_range(255)));
      endcase
      repeat ($urandom_range(0, 2)) push_digit();
    end
  endtask

  task automatic add_hemisphere(input logic [7:0] pos_ch, input logic [7:0] neg_ch);
    case ($urandom_range(9))
      0: ;
      1: push_byte(8'($urandom_range(8'h41, 8'h5A)));
      2: begin
        push_byte(8'h00);
        push_byte($urandom_range(1) ? pos_ch : neg_ch);
      end
      3: push_byte(8'h00);
      default: push_byte($urandom_range(1) ? pos_ch : neg_ch);
    endcase
  endtask

  task automatic add_random_sentence();
    int last_field;
    bit overlong;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
    case ($urandom_range(15))
      0:       push_text("$GP$GPRMC,");
      1:       push_text("$GPRMC$GPRMC,");
      2:       push_text("$GPGGA,");
      default: push_text("$GPRMC,");
    endcase
    last_field = ($urandom_range(4) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 9);
    overlong   = ($urandom_range(14) == 0);
    for (int f = 0; f <= last_field; f++) begin
      case (f)
        0: if ($urandom_range(1)) repeat ($urandom_range(1, 6)) push_digit();
        1: begin
          case ($urandom_range(19))
            0:       ;
            1:       push_text("V");
            2:       push_byte(8'($urandom_range(255)));
            3: begin
              push_byte(8'h00);
              push_text("A");
            end
            default: push_text("A");
          endcase
        end
        2, 4, 6: add_number();
        3: add_hemisphere(CH_N, "S");
        5: add_hemisphere(CH_E, "W");
        default: begin
          if (overlong) repeat ($urandom_range(40, 80)) push_digit();
          else repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
      endcase
      if (f < last_field) push_byte(CH_COMMA);
    end
    if (overlong && last_field < 7) repeat ($urandom_range(60, 80)) push_digit();
    push_byte(CH_STAR);
    if ($urandom_range(1)) push_text("5C\r\n");
    sentences_built++;
  endtask

  task automatic add_directed_sentences();
    push_text("$GPRMC,,A,,S,,W,,*");
    push_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
    push_text("$GPRMC,1,A,0000.00000,S,179.99999,W,0,,*");
    push_text("$GPRMC,1,V,12.5,N,1.0,E,3*");
    push_text("$GPRMC,1,,12.5,N,1.0,E,3*");
    push_text("$GPRMC,1,A,,S,,W,,*");
    push_text("$GPRMC,1,A,99999999999.9,N,21474.83647,E,21474.836479,*");
    push_text("$GPRMC,1,A,12.3.4x5,N,-7.25,E,9.1234567*");
    push_text("$GPRMC,1,A,5*");
    push_text("$G$GPRMC,1,A,1,N*$GPRMC$GPRMC,1,A,2,N*");
    push_text("$GPRMC,1,");
    push_byte(8'h00);
    push_text("A,3,");
    push_byte(8'h00);
    push_text("S,4,");
    push_byte(8'h00);
    push_text(",5*");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_text("$GPRMC,1,A,");
    push_byte(8'hD5);
    push_text("2");
    push_byte(CH_STAR);
    add_padded("1,A,2,N,3,E,4,", SENTENCE_MAX);
    add_padded("1,A,6,S,7,W,8,", SENTENCE_MAX + 1);
    push_text("$GPRMC,,A,,,,,,*");
    sentences_built += 14;
  endtask

  // ---------------------------------------------------------------- idling
  function automatic int sender_gap_pct();
    if (bytes_sent < total_bytes / 3) return 20;
    if (bytes_sent < 2 * total_bytes / 3) return 73;
    return 0;
  endfunction

  function automatic int receiver_gap_pct();
    if (bytes_sent < total_bytes / 3) return 73;
    if (bytes_sent < 2 * total_bytes / 3) return 20;
    return 0;
  endfunction

  // ---------------------------------------------------------- driver, sinks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (nmea_bytes.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= nmea_bytes.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= receiver_gap_pct());
    end
  end

  // input transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      bytes_sent++;
      track_rmc_byte(s_axis_tdata_i);
    end
  end

  task automatic flag_mismatch(input string what, input rmc_fix_t want, input logic [95:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected lat %0d lon %0d speed %0d all %0b", what,
               $realtime, $signed(want.lat), $signed(want.lon), want.speed, want.all_seen);
      $display("  got lat %0d lon %0d speed %0d all %0b", $signed(got[31:0]),
               $signed(got[63:32]), got[94:64], got[95]);
    end
  endtask

  // output transaction monitor
  always @(posedge clk_i) begin
    rmc_fix_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_fixes.size() == 0) begin
        want = '{default: '0};
        flag_mismatch("unexpected fix", want, m_axis_tdata_o);
      end else begin
        want = expected_fixes.pop_front();
        fixes_checked++;
        if (m_axis_tdata_o[31:0] != want.lat || m_axis_tdata_o[63:32] != want.lon ||
            m_axis_tdata_o[94:64] != want.speed || m_axis_tdata_o[95] != want.all_seen)
          flag_mismatch("field", want, m_axis_tdata_o);
      end
    end
  end

  // ------------------------------------------------------------------ main
  initial begin
    hunt_pos    = 0;
    in_sentence = 1'b0;
    field_no    = '0;
    body_len    = 0;
    dropped     = 1'b0;
    reset_field();
    held_lat    = '0;
    held_lon    = '0;
    held_speed  = '0;
    bytes_sent      = 0;
    fixes_checked   = 0;
    mismatches      = 0;
    sentences_built = 0;

    add_directed_sentences();
    while (nmea_bytes.size() < BYTE_TARGET) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
      add_random_sentence();
    end
    total_bytes = nmea_bytes.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (nmea_bytes.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_fixes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d sentences incl. noise and broken headers", bytes_sent,
             sentences_built);
    $display("checked %0d position fixes across three idling phases", fixes_checked);
    if (mismatches == 0 && expected_fixes.size() == 0) begin
      $display("nmea_rmc_position_parser regression: pass");
    end else begin
      $display("nmea_rmc_position_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d fixes outstanding", expected_fixes.size());
    $display("nmea_rmc_position_parser regression: fail");
    $finish;
  end

endmodule
